// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/hrisf_pkg.sv =====
// ---------------------------------------------------------------------------
// hrisf_pkg
// Widths, constants and control types of the heart rate interval filter.
// ---------------------------------------------------------------------------
package hrisf_pkg;

  localparam int IntervalBits = 14;
  localparam int CountBits    = (IntervalBits < 14) ? IntervalBits : 14;

  localparam int ByteW     = 8;
  localparam int SampleW   = 18;
  localparam int IntervalW = 17;
  localparam int RateW     = 13;

  localparam int NumW  = 26;
  localparam int ScaleW = 13;
  localparam logic [NumW-1:0]   RateNumerator = 26'd60000000;
  localparam logic [ScaleW-1:0] RateScale     = 13'd7789;

  localparam int ProdW    = CountBits + ScaleW;
  localparam int DivSteps = RateW;
  localparam int DshiftW  = ProdW + DivSteps - 1;
  localparam int StepCntW = $clog2(DivSteps);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StDone = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

// ===== hdl/hrisf_if.sv =====
// ---------------------------------------------------------------------------
// hrisf_in_if / hrisf_out_if
// Valid/ready channels for input requests and result requests.
// ---------------------------------------------------------------------------
interface hrisf_in_if;
  logic                        valid;
  logic                        ready;
  logic [hrisf_pkg::ByteW-1:0] ecg_byte_high;
  logic [hrisf_pkg::ByteW-1:0] ecg_byte_middle;
  logic [hrisf_pkg::ByteW-1:0] ecg_byte_low;
  logic [hrisf_pkg::ByteW-1:0] interval_byte_high;
  logic [hrisf_pkg::ByteW-1:0] interval_byte_low;

  modport source (
    output valid, ecg_byte_high, ecg_byte_middle, ecg_byte_low,
           interval_byte_high, interval_byte_low,
    input  ready
  );
  modport sink (
    input  valid, ecg_byte_high, ecg_byte_middle, ecg_byte_low,
           interval_byte_high, interval_byte_low,
    output ready
  );
endinterface

interface hrisf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [hrisf_pkg::SampleW-1:0]   ecg_sample;
  logic        [hrisf_pkg::IntervalW-1:0] interval_raw_ms;
  logic        [hrisf_pkg::RateW-1:0]     rate_raw_bpm;
  logic        [hrisf_pkg::IntervalW-1:0] interval_smoothed_ms;
  logic        [hrisf_pkg::RateW-1:0]     rate_smoothed_bpm;

  modport source (
    output valid, ecg_sample, interval_raw_ms, rate_raw_bpm,
           interval_smoothed_ms, rate_smoothed_bpm,
    input  ready
  );
  modport sink (
    input  valid, ecg_sample, interval_raw_ms, rate_raw_bpm,
           interval_smoothed_ms, rate_smoothed_bpm,
    output ready
  );
endinterface

// ===== hdl/hrisf_ctrl.sv =====
// ---------------------------------------------------------------------------
// hrisf_ctrl
// Sequencer for capture, divisor product, rate division and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hrisf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  hrisf_pkg::status_t status_i,
  output hrisf_pkg::cmd_t    cmd_o
);

  hrisf_pkg::state_e                 state_q, state_d;
  logic [hrisf_pkg::StepCntW-1:0]    step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hrisf_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = hrisf_pkg::StMul;
        end
      end
      hrisf_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        step_d    = hrisf_pkg::StepCntW'(hrisf_pkg::DivSteps - 1);
        state_d   = hrisf_pkg::StDiv;
      end
      hrisf_pkg::StDiv: begin
        cmd_o.step = 1'b1;
        step_d     = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = hrisf_pkg::StDone;
        end
      end
      hrisf_pkg::StDone: begin
        if (!status_i.out_valid || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = hrisf_pkg::StIdle;
        end
      end
      default: begin
        state_d = hrisf_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrisf_pkg::StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `ASSERT_ALWAYS(a_finish_room, clk_i, rst_ni,
                 !cmd_o.finish || !status_i.out_valid || out_ready_i)
  `ASSERT_NEXT(a_accept_to_mul, clk_i, rst_ni,
               in_valid_i && in_ready_o, state_q == hrisf_pkg::StMul)
  `ASSERT_NEXT(a_div_end, clk_i, rst_ni,
               state_q == hrisf_pkg::StDiv && step_q == '0,
               state_q == hrisf_pkg::StDone)

endmodule

// ===== hdl/hrisf_dpath.sv =====
// ---------------------------------------------------------------------------
// hrisf_dpath
// Sample assembly, restoring rate divider, slew state and result register.
// ---------------------------------------------------------------------------
module hrisf_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hrisf_pkg::cmd_t    cmd_i,
  output hrisf_pkg::status_t status_o,
  hrisf_in_if.sink           in_i,
  hrisf_out_if.source        out_o
);

  logic [hrisf_pkg::SampleW-1:0]   sample_q;
  logic [hrisf_pkg::CountBits-1:0] count_q;
  logic [hrisf_pkg::DshiftW-1:0]   dshift_q;
  logic [hrisf_pkg::NumW-1:0]      rem_q;
  logic [hrisf_pkg::RateW-1:0]     quo_q;

  logic                            seen_q;
  logic [hrisf_pkg::RateW-1:0]     prev_rate_q, prev_rate_d;
  logic [hrisf_pkg::IntervalW-1:0] prev_int_q, prev_int_d;

  logic                                   out_valid_q;
  logic signed [hrisf_pkg::SampleW-1:0]   o_sample_q;
  logic        [hrisf_pkg::IntervalW-1:0] o_int_raw_q;
  logic        [hrisf_pkg::RateW-1:0]     o_rate_raw_q;

  logic [15:0]                     rr_word;
  logic [hrisf_pkg::ProdW-1:0]     prod;
  logic                            ge;
  logic [hrisf_pkg::RateW-1:0]     rate_raw;
  logic [hrisf_pkg::IntervalW-1:0] int_raw;

  assign rr_word = {in_i.interval_byte_high, in_i.interval_byte_low};
  assign prod    = hrisf_pkg::ProdW'(count_q) * hrisf_pkg::ProdW'(hrisf_pkg::RateScale);
  assign ge      = hrisf_pkg::DshiftW'(rem_q) >= dshift_q;

  assign rate_raw = (count_q == '0) ? '0 : quo_q;
  assign int_raw  = hrisf_pkg::IntervalW'({count_q, 3'b000});

  always_comb begin
    prev_rate_d = rate_raw;
    prev_int_d  = int_raw;
    if (seen_q) begin
      prev_rate_d = prev_rate_q;
      if (rate_raw > prev_rate_q) begin
        prev_rate_d = prev_rate_q + 1'b1;
      end else if (rate_raw < prev_rate_q) begin
        prev_rate_d = prev_rate_q - 1'b1;
      end
      prev_int_d = prev_int_q;
      if (int_raw > prev_int_q) begin
        prev_int_d = prev_int_q + 1'b1;
      end else if (int_raw < prev_int_q) begin
        prev_int_d = prev_int_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= {in_i.ecg_byte_high, in_i.ecg_byte_middle, in_i.ecg_byte_low[7:6]};
      count_q  <= rr_word[hrisf_pkg::CountBits+1:2];
    end
    if (cmd_i.mul) begin
      dshift_q <= {prod, {(hrisf_pkg::DivSteps-1){1'b0}}};
      rem_q    <= hrisf_pkg::RateNumerator;
    end
    if (cmd_i.step) begin
      dshift_q <= dshift_q >> 1;
      quo_q    <= {quo_q[hrisf_pkg::RateW-2:0], ge};
      if (ge) begin
        rem_q <= rem_q - dshift_q[hrisf_pkg::NumW-1:0];
      end
    end
    if (cmd_i.finish) begin
      o_sample_q   <= sample_q;
      o_int_raw_q  <= int_raw;
      o_rate_raw_q <= rate_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_rate_q <= '0;
      prev_int_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        seen_q      <= 1'b1;
        prev_rate_q <= prev_rate_d;
        prev_int_q  <= prev_int_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_valid       = out_valid_q;
  assign out_o.valid              = out_valid_q;
  assign out_o.ecg_sample         = o_sample_q;
  assign out_o.interval_raw_ms    = o_int_raw_q;
  assign out_o.rate_raw_bpm       = o_rate_raw_q;
  assign out_o.interval_smoothed_ms = prev_int_q;
  assign out_o.rate_smoothed_bpm  = prev_rate_q;

endmodule

// ===== hdl/heart_rate_interval_slew_filter_core.sv =====
// ---------------------------------------------------------------------------
// heart_rate_interval_slew_filter_core
// ECG sample assembly with heart rate and interval slew filtering.
// ---------------------------------------------------------------------------
// Input requests carry three ECG FIFO bytes and two R-to-R bytes on in_i;
// each produces exactly one result request on out_o with the signed sample,
// the raw interval (count times eight), the raw rate 60000000/(count*7789)
// and the slew-limited interval and rate.
// An accepted request first has its divisor product formed, then passes
// through the restoring divider, one quotient bit per cycle, and then
// loads the result register. A new request is accepted only once that
// result has been loaded and the block is back in its idle state.
// The result register lets the next request be accepted and worked on while
// a result waits; if the receiver still stalls when the next result is
// ready, the block holds it and accepts nothing further until out_o drains.
// Reset clears the handshake state and the slew state, so the first request
// after reset loads the smoothed outputs from the raw values.
// ---------------------------------------------------------------------------
module heart_rate_interval_slew_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrisf_in_if.sink    in_i,
  hrisf_out_if.source out_o
);

  hrisf_pkg::cmd_t    cmd;
  hrisf_pkg::status_t status;

  hrisf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hrisf_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

// ===== tb/sv/heart_rate_interval_slew_filter_core_tb.sv =====
// ---------------------------------------------------------------------------
// heart_rate_interval_slew_filter_core_tb
// Self-checking testbench for the heart rate interval slew filter core.
// ---------------------------------------------------------------------------
// Requests are driven on the input channel and each result request is
// compared with a prediction made in the testbench. The prediction covers
// the sample assembly, the interval and rate arithmetic and the slew
// limiting. Stimulus runs from directed corner cases to slowly varying
// interval streams with random noise. Both sides idle at random, and the
// receiver holds off for a long stretch once so that the core stalls.
// ---------------------------------------------------------------------------
module heart_rate_interval_slew_filter_core_tb;

  typedef struct packed {
    logic signed [hrisf_pkg::SampleW-1:0] ecg_sample;
    logic [hrisf_pkg::IntervalW-1:0]      interval_raw_ms;
    logic [hrisf_pkg::RateW-1:0]          rate_raw_bpm;
    logic [hrisf_pkg::IntervalW-1:0]      interval_smoothed_ms;
    logic [hrisf_pkg::RateW-1:0]          rate_smoothed_bpm;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrisf_in_if  in_if ();
  hrisf_out_if out_if ();

  heart_rate_interval_slew_filter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  reading_t                        pending_readings[$];
  logic                            rate_tracked_valid;
  logic [hrisf_pkg::RateW-1:0]     rate_tracked;
  logic [hrisf_pkg::IntervalW-1:0] interval_tracked;
  int unsigned                     error_count;
  int unsigned                     hold_off_left;
  logic                            sender_idles;
  logic                            receiver_idles;

  function automatic reading_t predict_reading(
    input logic [hrisf_pkg::ByteW-1:0] eh, em, el, ih, il
  );
    reading_t    r;
    logic [31:0] count;
    logic [63:0] divisor;
    count = ({16'd0, ih, il} >> 2) & ((32'd1 << hrisf_pkg::IntervalBits) - 32'd1);
    r.ecg_sample      = {eh, em, el[7:6]};
    r.interval_raw_ms = hrisf_pkg::IntervalW'(count * 8);
    r.rate_raw_bpm    = '0;
    if (count != 0) begin
      divisor        = 64'(count) * 64'd7789;
      r.rate_raw_bpm = hrisf_pkg::RateW'(64'd60000000 / divisor);
    end
    if (!rate_tracked_valid) begin
      rate_tracked       = r.rate_raw_bpm;
      interval_tracked   = r.interval_raw_ms;
      rate_tracked_valid = 1'b1;
    end else begin
      if (r.rate_raw_bpm > rate_tracked) rate_tracked = rate_tracked + 1'b1;
      else if (r.rate_raw_bpm < rate_tracked) rate_tracked = rate_tracked - 1'b1;
      if (r.interval_raw_ms > interval_tracked) interval_tracked = interval_tracked + 1'b1;
      else if (r.interval_raw_ms < interval_tracked) interval_tracked = interval_tracked - 1'b1;
    end
    r.interval_smoothed_ms = interval_tracked;
    r.rate_smoothed_bpm    = rate_tracked;
    return r;
  endfunction

  task automatic send_reading(input logic [hrisf_pkg::ByteW-1:0] eh, em, el, ih, il);
    while (sender_idles && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid              <= 1'b1;
    in_if.ecg_byte_high      <= eh;
    in_if.ecg_byte_middle    <= em;
    in_if.ecg_byte_low       <= el;
    in_if.interval_byte_high <= ih;
    in_if.interval_byte_low  <= il;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_readings.push_back(predict_reading(eh, em, el, ih, il));
  endtask

  task automatic send_count(input logic [hrisf_pkg::ByteW-1:0] eh, em, el,
                            input logic [13:0] count);
    logic [15:0] word;
    word = {count, 2'($urandom)};
    send_reading(eh, em, el, word[15:8], word[7:0]);
  endtask

  task automatic check_reading();
    reading_t got;
    reading_t want;
    got = '{out_if.ecg_sample, out_if.interval_raw_ms, out_if.rate_raw_bpm,
            out_if.interval_smoothed_ms, out_if.rate_smoothed_bpm};
    if (pending_readings.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected result: sample %0d interval %0d rate %0d smoothed %0d/%0d",
                 got.ecg_sample, got.interval_raw_ms, got.rate_raw_bpm,
                 got.interval_smoothed_ms, got.rate_smoothed_bpm);
    end else begin
      want = pending_readings.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= 10)
          $display({"mismatch: sample %0d/%0d interval %0d/%0d rate %0d/%0d ",
                    "smoothed interval %0d/%0d smoothed rate %0d/%0d (expected/actual)"},
                   want.ecg_sample, got.ecg_sample,
                   want.interval_raw_ms, got.interval_raw_ms,
                   want.rate_raw_bpm, got.rate_raw_bpm,
                   want.interval_smoothed_ms, got.interval_smoothed_ms,
                   want.rate_smoothed_bpm, got.rate_smoothed_bpm);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_reading();
    if (hold_off_left != 0) begin
      out_if.ready  <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_if.ready <= !(receiver_idles && $urandom_range(99) < 10);
    end
  end

  task automatic test_corner_readings();
    // The first request after reset has a zero interval, the second repeats it.
    send_count(8'h00, 8'h00, 8'h00, 14'd0);
    send_count(8'h00, 8'h00, 8'h3f, 14'd0);
    send_count(8'h80, 8'h00, 8'h00, 14'd1);
    send_count(8'h7f, 8'hff, 8'hc0, 14'd1);
    send_count(8'hff, 8'hff, 8'hff, 14'h3fff);
    send_reading(8'hff, 8'hff, 8'h40, 8'hff, 8'hff);
    send_reading(8'h00, 8'h01, 8'h80, 8'h00, 8'h03);
    send_reading(8'h55, 8'haa, 8'h7f, 8'haa, 8'h55);
    send_reading(8'haa, 8'h55, 8'h80, 8'h55, 8'haa);
    send_count(8'h01, 8'h80, 8'h00, 14'd200);
    send_count(8'h12, 8'h34, 8'h56, 14'd200);
    send_count(8'h40, 8'h00, 8'h00, 14'd199);
    send_count(8'hc0, 8'h00, 8'hc0, 14'd0);
    send_count(8'h00, 8'h00, 8'h00, 14'd0);
    send_count(8'h00, 8'h00, 8'h00, 14'd2);
  endtask

  task automatic test_tracking_stream(input int n);
    int          count;
    int          run_left;
    int unsigned pick;
    count    = $urandom_range(100, 400);
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        pick = $urandom_range(99);
        if (pick < 60) count = count + $urandom_range(4) - 2;
        else if (pick < 85) count = $urandom_range(100, 400);
        else count = $urandom_range(16383);
        if (count < 0) count = 0;
        if (count > 16383) count = 16383;
        run_left = $urandom_range(1, 25);
      end
      run_left--;
      if ($urandom_range(99) < 15)
        send_reading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_count(8'($urandom), 8'($urandom), 8'($urandom), 14'(count));
    end
  endtask

  task automatic test_receiver_hold_off();
    hold_off_left <= 300;
    for (int i = 0; i < 10; i++)
      send_count(8'($urandom), 8'($urandom), 8'($urandom), 14'($urandom_range(100, 400)));
  endtask

  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_tracking_stream(150);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    in_if.valid              = 1'b0;
    in_if.ecg_byte_high      = '0;
    in_if.ecg_byte_middle    = '0;
    in_if.ecg_byte_low       = '0;
    in_if.interval_byte_high = '0;
    in_if.interval_byte_low  = '0;
    out_if.ready             = 1'b0;
    rate_tracked_valid       = 1'b0;
    rate_tracked             = '0;
    interval_tracked         = '0;
    error_count              = 0;
    hold_off_left            = 0;
    sender_idles             = 1'b1;
    receiver_idles           = 1'b1;
    rst_ni                   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_readings();
    test_tracking_stream(300);
    test_receiver_hold_off();
    test_back_to_back();
    test_tracking_stream(180);
    in_if.valid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("heart_rate_interval_slew_filter_core_tb: done, clean");
    end else begin
      $display("heart_rate_interval_slew_filter_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("heart_rate_interval_slew_filter_core_tb: done, errors");
    $finish;
  end

endmodule
